// ----- hdl/sgal_pkg.sv -----
// Shared types and sign tables for the quaternion sign alignment pipeline.
`timescale 1ns / 1ps
`default_nettype none
package sgal_pkg;

  localparam int NUM_COMP  = 4;
  localparam int NUM_UNITS = 8;

  typedef logic signed [15:0] comp_t;
  typedef logic signed [31:0] prod_t;
  typedef logic signed [33:0] dot_t;
  typedef logic        [2:0]  idx_t;
  typedef logic        [1:0]  comp_idx_t;

  typedef comp_t quat_t [NUM_COMP];

  // Unit quaternion family; the low index bit selects the negated member.
  typedef enum logic [1:0] {
    UNIT_ONE = 2'd0,
    UNIT_I   = 2'd1,
    UNIT_J   = 2'd2,
    UNIT_K   = 2'd3
  } unit_t;

  // Left product u*Q takes output component j from input component (j xor unit).
  function automatic comp_idx_t perm_src(unit_t u, comp_idx_t j);
    return comp_idx_t'(u) ^ j;
  endfunction

  // Bit j set when output component j of u*Q is negated, for the positive unit.
  function automatic logic [3:0] perm_neg(unit_t u);
    logic [3:0] mask;
    case (u)
      UNIT_ONE: mask = 4'b0000;
      UNIT_I:   mask = 4'b0101;
      UNIT_J:   mask = 4'b1001;
      UNIT_K:   mask = 4'b0011;
      default:  mask = 4'b0000;
    endcase
    return mask;
  endfunction

  // True when candidate idx negates its component j.
  function automatic logic cand_neg(idx_t idx, comp_idx_t j);
    logic [3:0] mask;
    mask = perm_neg(unit_t'(idx[2:1]));
    return mask[j] ^ idx[0];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/sgal_product_stage.sv -----
// First pipeline stage: all sixteen cross products of reference and input components.
`timescale 1ns / 1ps
`default_nettype none
module sgal_product_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic             down_ready,
  input  wire sgal_pkg::quat_t  ref_q,
  input  wire sgal_pkg::quat_t  in_q,
  output logic                  valid_r,
  output sgal_pkg::prod_t       prod_r [4][4],
  output logic [3:0]            qmin_r,
  output sgal_pkg::quat_t       q_r
);
  import sgal_pkg::*;

  logic load;

  assign up_ready = !valid_r || down_ready;
  assign load     = up_valid && up_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // Row j is the reference component, column k the input component.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < NUM_COMP; j++) begin
        for (int k = 0; k < NUM_COMP; k++) begin
          prod_r[j][k] <= prod_t'(ref_q[j] * in_q[k]);
        end
        // Negating the most negative code wraps back onto itself.
        qmin_r[j] <= (in_q[j] == comp_t'(16'sh8000));
        q_r[j]    <= in_q[j];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgal_dot_stage.sv -----
// Second pipeline stage: dot product of every candidate with the reference.
`timescale 1ns / 1ps
`default_nettype none
module sgal_dot_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic             down_ready,
  input  wire sgal_pkg::prod_t  prod [4][4],
  input  wire logic [3:0]       qmin,
  input  wire sgal_pkg::quat_t  q,
  output logic                  valid_r,
  output sgal_pkg::dot_t        dot_r [8],
  output sgal_pkg::quat_t       q_r
);
  import sgal_pkg::*;

  logic load;
  dot_t dot_nxt [NUM_UNITS];

  assign up_ready = !valid_r || down_ready;
  assign load     = up_valid && up_ready;

  // A negated term keeps its sign when the source component is the most
  // negative code, matching the wrapped candidate value.
  always_comb begin
    idx_t      n;
    comp_idx_t jj;
    comp_idx_t src;
    prod_t     term;
    dot_t      acc;
    for (int i = 0; i < NUM_UNITS; i++) begin
      n   = idx_t'(i);
      acc = '0;
      for (int j = 0; j < NUM_COMP; j++) begin
        jj   = comp_idx_t'(j);
        src  = perm_src(unit_t'(n[2:1]), jj);
        term = prod[j][src];
        if (cand_neg(n, jj) && !qmin[src]) begin
          term = -term;
        end
        acc = acc + dot_t'(term);
      end
      dot_nxt[i] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dot_r <= dot_nxt;
      q_r   <= q;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sgal_select_stage.sv -----
// Third and fourth pipeline stages: maximum search and forming of the winning candidate.
`timescale 1ns / 1ps
`default_nettype none
module sgal_select_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire logic             down_ready,
  input  wire sgal_pkg::dot_t   dot [8],
  input  wire sgal_pkg::quat_t  q,
  output logic                  valid_r,
  output sgal_pkg::quat_t       cand_r,
  output sgal_pkg::idx_t        idx_r
);
  import sgal_pkg::*;

  // Pair winners after two compare levels.
  logic    pair_valid_r;
  logic    pair_ready;
  logic    out_ready;
  dot_t    pair_dot_r [2];
  idx_t    pair_idx_r [2];
  quat_t   pair_q_r;
  dot_t    pair_dot_nxt [2];
  idx_t    pair_idx_nxt [2];
  idx_t    win_idx;
  quat_t   cand_nxt;

  assign out_ready  = !valid_r || down_ready;
  assign pair_ready = !pair_valid_r || out_ready;
  assign up_ready   = pair_ready;

  // The lower index is kept unless the higher one is strictly larger.
  always_comb begin
    dot_t l1_dot [4];
    idx_t l1_idx [4];
    for (int k = 0; k < 4; k++) begin
      if (dot[2*k+1] > dot[2*k]) begin
        l1_dot[k] = dot[2*k+1];
        l1_idx[k] = idx_t'(2*k+1);
      end else begin
        l1_dot[k] = dot[2*k];
        l1_idx[k] = idx_t'(2*k);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (l1_dot[2*k+1] > l1_dot[2*k]) begin
        pair_dot_nxt[k] = l1_dot[2*k+1];
        pair_idx_nxt[k] = l1_idx[2*k+1];
      end else begin
        pair_dot_nxt[k] = l1_dot[2*k];
        pair_idx_nxt[k] = l1_idx[2*k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_valid_r <= 1'b0;
    end else if (pair_ready) begin
      pair_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && pair_ready) begin
      pair_dot_r <= pair_dot_nxt;
      pair_idx_r <= pair_idx_nxt;
      pair_q_r   <= q;
    end
  end

  // Final compare, then rebuild the chosen candidate from the input quaternion.
  always_comb begin
    comp_idx_t jj;
    comp_idx_t src;
    win_idx = (pair_dot_r[1] > pair_dot_r[0]) ? pair_idx_r[1] : pair_idx_r[0];
    for (int j = 0; j < NUM_COMP; j++) begin
      jj  = comp_idx_t'(j);
      src = perm_src(unit_t'(win_idx[2:1]), jj);
      cand_nxt[j] = cand_neg(win_idx, jj) ? comp_t'(-pair_q_r[src]) : pair_q_r[src];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= pair_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pair_valid_r && out_ready) begin
      cand_r <= cand_nxt;
      idx_r  <= win_idx;
    end
  end

  // A held pair must not change while the output stage is blocked.
  a_pair_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pair_valid_r && !out_ready |=> pair_valid_r && $stable(pair_idx_r[0])
      && $stable(pair_idx_r[1]))
    else $error("pair stage changed while blocked");

  // The chosen index always comes from one of the two held pairs.
  a_win_from_pair: assert property (@(posedge clk) disable iff (!rst_n)
    pair_valid_r |-> (win_idx == pair_idx_r[0]) || (win_idx == pair_idx_r[1]))
    else $error("winner not taken from a pair");

endmodule
`default_nettype wire

// ----- hdl/quaternion_sign_align_unit.sv -----
// Top level of the quaternion sign alignment pipeline.
//
//  channel  | beat fields                                   | handshake
//  ---------+-----------------------------------------------+---------------------
//  input    | in_ref_w/x/y/z, in_w/x/y/z (Q1.15)            | in_valid, in_stall
//  result   | out_w/x/y/z (Q1.15), out_chosen_index (0..7)  | out_valid, out_stall
//
// An accepted beat passes through four register stages (products, dots, pair compare,
// final compare) into the result register; one beat enters every cycle while
// in_stall is low.
// Reset (rst_n low at a clock edge) clears the valid bit of every stage.
// A stall on the result side backs up stage by stage; a stage with a free slot
// still accepts, so no beat is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_sign_align_unit (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    in_ref_w,
  input  wire logic signed [15:0]    in_ref_x,
  input  wire logic signed [15:0]    in_ref_y,
  input  wire logic signed [15:0]    in_ref_z,
  input  wire logic signed [15:0]    in_w,
  input  wire logic signed [15:0]    in_x,
  input  wire logic signed [15:0]    in_y,
  input  wire logic signed [15:0]    in_z,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic signed [15:0]         out_w,
  output logic signed [15:0]         out_x,
  output logic signed [15:0]         out_y,
  output logic signed [15:0]         out_z,
  output logic        [2:0]          out_chosen_index
);
  import sgal_pkg::*;

  quat_t ref_q;
  quat_t in_q;

  // Stage handshakes: prod feeds dot, dot feeds select.
  logic  prod_valid;
  logic  dot_valid;
  logic  prod_up_ready;
  logic  dot_up_ready;
  logic  dot_down_ready;

  prod_t prod   [NUM_COMP][NUM_COMP];
  logic  [3:0]  qmin;
  quat_t prod_q;
  dot_t  dots   [NUM_UNITS];
  quat_t dot_q;
  quat_t cand;
  idx_t  idx;

  assign ref_q = '{in_ref_w, in_ref_x, in_ref_y, in_ref_z};
  assign in_q  = '{in_w, in_x, in_y, in_z};

  assign in_stall = !prod_up_ready;

  // Every cross product of the reference and input components, registered.
  sgal_product_stage u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (prod_up_ready),
    .down_ready (dot_up_ready),
    .ref_q      (ref_q),
    .in_q       (in_q),
    .valid_r    (prod_valid),
    .prod_r     (prod),
    .qmin_r     (qmin),
    .q_r        (prod_q)
  );

  // Eight candidate dot products, built from signed sums of the cross products.
  sgal_dot_stage u_dot (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (prod_valid),
    .up_ready   (dot_up_ready),
    .down_ready (dot_down_ready),
    .prod       (prod),
    .qmin       (qmin),
    .q          (prod_q),
    .valid_r    (dot_valid),
    .dot_r      (dots),
    .q_r        (dot_q)
  );

  // Maximum search with lowest index on ties, then the chosen candidate.
  sgal_select_stage u_sel (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (dot_valid),
    .up_ready   (dot_down_ready),
    .down_ready (!out_stall),
    .dot        (dots),
    .q          (dot_q),
    .valid_r    (out_valid),
    .cand_r     (cand),
    .idx_r      (idx)
  );

  assign out_w            = cand[0];
  assign out_x            = cand[1];
  assign out_y            = cand[2];
  assign out_z            = cand[3];
  assign out_chosen_index = idx;

  // With the result side free the whole pipeline moves, so input is never held.
  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input held although result side is free");

  // An accepted beat always occupies the product stage on the next cycle.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> prod_valid)
    else $error("accepted beat did not enter the product stage");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !prod_valid && !dot_valid)
    else $error("pipeline not empty after reset");

  // A full dot stage that cannot move on must keep its beat.
  a_dot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dot_valid && !dot_down_ready |=> dot_valid)
    else $error("dot stage dropped a blocked beat");

endmodule
`default_nettype wire
